FILE: rtl/core/macd_pkg.sv
`default_nettype none

package macd_pkg;

  // Q1.16 weight of one EMA
  localparam int WEIGHT_FRAC = 16;
  localparam int WEIGHT_W    = WEIGHT_FRAC + 1;
  localparam int PERIOD_W    = 16;

  // operand slice fed to the shared multiplier each cycle
  localparam int MUL_CHUNK   = 25;

  // dividend 2^(WEIGHT_FRAC+1) has WEIGHT_FRAC+2 bits: one quotient bit per step
  localparam int DIV_STEPS   = WEIGHT_FRAC + 2;

  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 16'd12;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 16'd26;
  localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 16'd9;

  localparam logic [WEIGHT_W-1:0] FAST_WEIGHT_RST =
    WEIGHT_W'((2 ** (WEIGHT_FRAC + 1)) / (12 + 1));
  localparam logic [WEIGHT_W-1:0] SLOW_WEIGHT_RST =
    WEIGHT_W'((2 ** (WEIGHT_FRAC + 1)) / (26 + 1));
  localparam logic [WEIGHT_W-1:0] SIGNAL_WEIGHT_RST =
    WEIGHT_W'((2 ** (WEIGHT_FRAC + 1)) / (9 + 1));

  typedef enum logic [1:0] {
    CFG_FAST   = 2'd0,
    CFG_SLOW   = 2'd1,
    CFG_SIGNAL = 2'd2,
    CFG_DOUBLE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_FAST  = 3'd0,
    OP_FAST2 = 3'd1,
    OP_SLOW  = 3'd2,
    OP_SLOW2 = 3'd3,
    OP_SIG   = 3'd4,
    OP_SIG2  = 3'd5
  } ema_op_t;

  typedef struct packed {
    logic    capture;
    logic    load_price;
    logic    load_sig;
    logic    sub;
    logic    mac;
    logic    add;
    logic    load_out;
    ema_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mac_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/macd_cfg.sv
`default_nettype none

module macd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [macd_pkg::PERIOD_W-1:0]  cfg_wdata,
  output logic      [macd_pkg::WEIGHT_W-1:0]  fast_k,
  output logic      [macd_pkg::WEIGHT_W-1:0]  slow_k,
  output logic      [macd_pkg::WEIGHT_W-1:0]  sig_k,
  output logic                                dbl,
  output logic                                busy
);
  import macd_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [PERIOD_W-1:0]  per_r    [0:2];
  logic [PERIOD_W-1:0]  per_nxt  [0:2];
  logic [WEIGHT_W-1:0]  wgt_r    [0:2];
  logic [WEIGHT_W-1:0]  wgt_nxt  [0:2];
  logic                 dbl_r, dbl_nxt;
  logic [2:0]           pend_r, pend_nxt;
  logic                 run_r, run_nxt;
  logic [1:0]           cur_r, cur_nxt;
  logic [WEIGHT_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_STEPS-1:0] rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] dvd_r, dvd_nxt;
  logic [DIV_STEPS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [1:0]           pick;
  logic [PERIOD_W-1:0]  pick_per;
  logic [DIV_STEPS-1:0] rem_sh;
  logic                 ge;

  always_comb begin
    if (pend_r[CFG_FAST]) begin
      pick = CFG_FAST;
    end else if (pend_r[CFG_SLOW]) begin
      pick = CFG_SLOW;
    end else begin
      pick = CFG_SIGNAL;
    end
  end

  assign pick_per = per_r[pick];
  assign rem_sh   = {rem_r[DIV_STEPS-2:0], dvd_r[DIV_STEPS-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    per_nxt  = per_r;
    wgt_nxt  = wgt_r;
    dbl_nxt  = dbl_r;
    pend_nxt = pend_r;
    run_nxt  = run_r;
    cur_nxt  = cur_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;

    if (run_r) begin
      // restoring division, one quotient bit a cycle
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[DIV_STEPS-2:0], ge};
      dvd_nxt = {dvd_r[DIV_STEPS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        run_nxt        = 1'b0;
        wgt_nxt[cur_r] = quo_nxt[WEIGHT_W-1:0];
      end
    end else if (|pend_r) begin
      run_nxt       = 1'b1;
      cur_nxt       = pick;
      pend_nxt[pick] = 1'b0;
      // period zero behaves as period one
      dvs_nxt = (pick_per == '0) ? WEIGHT_W'(2) : ({1'b0, pick_per} + 1'b1);
      rem_nxt = '0;
      quo_nxt = '0;
      dvd_nxt = {1'b1, {(DIV_STEPS-1){1'b0}}};
      cnt_nxt = '0;
    end

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FAST, CFG_SLOW, CFG_SIGNAL: begin
          per_nxt[cfg_index]  = cfg_wdata;
          pend_nxt[cfg_index] = 1'b1;
          // drop a division that works on the old period
          if (run_nxt && (cur_nxt == cfg_index)) begin
            run_nxt = 1'b0;
          end
        end
        CFG_DOUBLE: dbl_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r[CFG_FAST]   <= FAST_PERIOD_RST;
      per_r[CFG_SLOW]   <= SLOW_PERIOD_RST;
      per_r[CFG_SIGNAL] <= SIGNAL_PERIOD_RST;
      wgt_r[CFG_FAST]   <= FAST_WEIGHT_RST;
      wgt_r[CFG_SLOW]   <= SLOW_WEIGHT_RST;
      wgt_r[CFG_SIGNAL] <= SIGNAL_WEIGHT_RST;
      dbl_r    <= 1'b0;
      pend_r   <= '0;
      run_r    <= 1'b0;
      cur_r    <= '0;
      cnt_r    <= '0;
    end else begin
      per_r  <= per_nxt;
      wgt_r  <= wgt_nxt;
      dbl_r  <= dbl_nxt;
      pend_r <= pend_nxt;
      run_r  <= run_nxt;
      cur_r  <= cur_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign fast_k = wgt_r[CFG_FAST];
  assign slow_k = wgt_r[CFG_SLOW];
  assign sig_k  = wgt_r[CFG_SIGNAL];
  assign dbl    = dbl_r;
  assign busy   = run_r || (|pend_r);

endmodule

`default_nettype wire

FILE: rtl/core/macd_dp.sv
`default_nettype none

module macd_dp #(
  parameter int PRICE_WIDTH     = 32,
  parameter int EXTRA_FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire macd_pkg::dp_cmd_t                  cmd,
  output macd_pkg::dp_stat_t                      stat,
  input  wire logic        [PRICE_WIDTH-1:0]      in_price,
  input  wire logic        [macd_pkg::WEIGHT_W-1:0] fast_k,
  input  wire logic        [macd_pkg::WEIGHT_W-1:0] slow_k,
  input  wire logic        [macd_pkg::WEIGHT_W-1:0] sig_k,
  input  wire logic                               dbl,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output logic signed      [PRICE_WIDTH:0]        out_macd_value,
  output logic signed      [PRICE_WIDTH:0]        out_signal_value,
  output logic signed      [PRICE_WIDTH+1:0]      out_hist_value
);
  import macd_pkg::*;

  localparam int EW   = PRICE_WIDTH + EXTRA_FRAC_BITS;
  localparam int DW   = EW + 2;
  localparam int NCH  = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int DPAD = NCH * MUL_CHUNK;
  localparam int KW   = WEIGHT_W + 1;
  localparam int CPW  = MUL_CHUNK + 1;
  localparam int PPW  = KW + CPW;
  localparam int AW   = DPAD + KW;
  localparam int MSW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int OW   = PRICE_WIDTH + 1;

  logic        [EW-1:0]   x_r;
  logic        [EW-1:0]   fast_r, fast2_r, slow_r, slow2_r;
  logic signed [DW-1:0]   sig_r, sig2_r;
  logic signed [DPAD-1:0] d_r;
  logic signed [AW-1:0]   acc_r;
  logic        [MSW-1:0]  mstep_r;
  logic                   out_valid_r;
  logic signed [OW-1:0]   macd_r, signal_r;
  logic signed [OW:0]     hist_r;

  logic signed [DW-1:0]   line, sig_sel, e_sel, x_sel, diff, incr, e_new;
  logic        [WEIGHT_W-1:0] k_sel;
  logic        [MUL_CHUNK-1:0] chunk;
  logic                   last;
  logic signed [CPW-1:0]  cop;
  logic signed [KW-1:0]   kop;
  logic signed [PPW-1:0]  pp;
  logic signed [AW-1:0]   pp_sh;
  logic signed [OW-1:0]   mv, sv;

  assign line = dbl ? ($signed({2'b00, fast2_r}) - $signed({2'b00, slow2_r}))
                    : ($signed({2'b00, fast_r}) - $signed({2'b00, slow_r}));
  assign sig_sel = dbl ? sig2_r : sig_r;

  always_comb begin
    case (cmd.op)
      OP_FAST: begin
        e_sel = $signed({2'b00, fast_r});
        x_sel = $signed({2'b00, x_r});
        k_sel = fast_k;
      end
      OP_FAST2: begin
        e_sel = $signed({2'b00, fast2_r});
        x_sel = $signed({2'b00, fast_r});
        k_sel = fast_k;
      end
      OP_SLOW: begin
        e_sel = $signed({2'b00, slow_r});
        x_sel = $signed({2'b00, x_r});
        k_sel = slow_k;
      end
      OP_SLOW2: begin
        e_sel = $signed({2'b00, slow2_r});
        x_sel = $signed({2'b00, slow_r});
        k_sel = slow_k;
      end
      OP_SIG: begin
        e_sel = sig_r;
        x_sel = line;
        k_sel = sig_k;
      end
      OP_SIG2: begin
        e_sel = sig2_r;
        x_sel = sig_r;
        k_sel = sig_k;
      end
      default: begin
        e_sel = '0;
        x_sel = '0;
        k_sel = '0;
      end
    endcase
  end

  assign diff = x_sel - e_sel;

  // low slices unsigned, top slice carries the sign
  assign chunk = d_r[MUL_CHUNK-1:0];
  assign last  = (mstep_r == MSW'(NCH - 1));
  assign cop   = last ? $signed({chunk[MUL_CHUNK-1], chunk}) : $signed({1'b0, chunk});
  assign kop   = $signed({1'b0, k_sel});
  assign pp    = kop * cop;
  assign pp_sh = AW'(pp) <<< (mstep_r * MUL_CHUNK);

  // floor(k*d / 2^16) is an arithmetic shift of the exact product
  assign incr  = DW'(acc_r >>> WEIGHT_FRAC);
  assign e_new = e_sel + incr;

  assign mv = OW'(line >>> EXTRA_FRAC_BITS);
  assign sv = OW'(sig_sel >>> EXTRA_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r      <= '0;
      fast2_r     <= '0;
      slow_r      <= '0;
      slow2_r     <= '0;
      sig_r       <= '0;
      sig2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_price) begin
        fast_r  <= x_r;
        fast2_r <= x_r;
        slow_r  <= x_r;
        slow2_r <= x_r;
      end
      if (cmd.load_sig) begin
        sig_r  <= line;
        sig2_r <= line;
      end
      if (cmd.add) begin
        case (cmd.op)
          OP_FAST:  fast_r  <= EW'(e_new);
          OP_FAST2: fast2_r <= EW'(e_new);
          OP_SLOW:  slow_r  <= EW'(e_new);
          OP_SLOW2: slow2_r <= EW'(e_new);
          OP_SIG:   sig_r   <= e_new;
          OP_SIG2:  sig2_r  <= e_new;
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= {in_price, {EXTRA_FRAC_BITS{1'b0}}};
    end
    if (cmd.sub) begin
      d_r     <= DPAD'(diff);
      acc_r   <= '0;
      mstep_r <= '0;
    end else if (cmd.mac) begin
      d_r     <= d_r >>> MUL_CHUNK;
      acc_r   <= acc_r + pp_sh;
      mstep_r <= mstep_r + 1'b1;
    end
    if (cmd.load_out) begin
      macd_r   <= mv;
      signal_r <= sv;
      hist_r   <= (OW+1)'(mv) - (OW+1)'(sv);
    end
  end

  assign stat = '{mac_last: last, out_busy: out_valid_r && out_stall};

  assign out_valid        = out_valid_r;
  assign out_macd_value   = macd_r;
  assign out_signal_value = signal_r;
  assign out_hist_value   = hist_r;

endmodule

`default_nettype wire

FILE: rtl/core/macd_ctrl.sv
`default_nettype none

module macd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_series_start,
  input  wire logic               wbusy,
  output logic                    in_stall,
  output macd_pkg::dp_cmd_t       cmd,
  input  wire macd_pkg::dp_stat_t stat
);
  import macd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_LOADSIG,
    S_SUB,
    S_MUL,
    S_ADD,
    S_RESULT
  } state_t;

  state_t  state_r, state_nxt;
  ema_op_t op_r, op_nxt;
  logic    accept;

  assign in_stall = !((state_r == S_IDLE) && !wbusy);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = OP_FAST;
          state_nxt = in_series_start ? S_LOAD : S_SUB;
        end
      end
      S_LOAD:    state_nxt = S_LOADSIG;
      S_LOADSIG: state_nxt = S_RESULT;
      S_SUB:     state_nxt = S_MUL;
      S_MUL: begin
        if (stat.mac_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (op_r == OP_SIG2) begin
          state_nxt = S_RESULT;
        end else begin
          op_nxt    = ema_op_t'(op_r + 3'd1);
          state_nxt = S_SUB;
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_FAST;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = op_r;
    cmd.capture    = accept;
    cmd.load_price = (state_r == S_LOAD);
    cmd.load_sig   = (state_r == S_LOADSIG);
    cmd.sub        = (state_r == S_SUB);
    cmd.mac        = (state_r == S_MUL);
    cmd.add        = (state_r == S_ADD);
    cmd.load_out   = (state_r == S_RESULT) && !stat.out_busy;
  end

endmodule

`default_nettype wire

FILE: rtl/core/macd_indicator_core.sv
`default_nettype none

// MACD indicator core. Each accepted item carries one unsigned Q16.16 price and
// a series-start flag; each item yields exactly one result holding the MACD line
// (fast minus slow EMA), the signal line (EMA of the MACD line) and the
// histogram (MACD minus signal), all signed Q16.16 rounded toward minus infinity.
// Averages keep EXTRA_FRAC_BITS more fraction bits than the price and use the
// weight floor(2^17/(n+1)) in Q1.16; a period of 0 acts as 1. With double
// smoothing set, each average is followed by a second EMA of the same weight and
// the second one drives the outputs. A series start loads every average with its
// input. The six EMA updates of an item run one after another through a
// single shared 18 x 26 bit multiplier; each update is a subtract step, one
// multiply step per 25-bit slice of the difference and an add step, with
// ceil((PRICE_WIDTH + EXTRA_FRAC_BITS + 2) / 25) slices; a series-start item
// skips the updates. A result waits in the output register while the next
// item is already being worked on. Writing a period register starts a restoring
// division for its weight; in_stall stays high until all weights are current.
// Write configuration only while no item is in flight.

module macd_indicator_core #(
  parameter int PRICE_WIDTH     = 32,
  parameter int EXTRA_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // price input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [PRICE_WIDTH-1:0]     in_price,
  input  wire logic                              in_series_start,
  // results
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [PRICE_WIDTH:0]       out_macd_value,
  output logic signed      [PRICE_WIDTH:0]       out_signal_value,
  output logic signed      [PRICE_WIDTH+1:0]     out_hist_value,
  // register writes
  input  wire logic                              cfg_we,
  input  wire logic        [1:0]                 cfg_index,
  input  wire logic        [macd_pkg::PERIOD_W-1:0] cfg_wdata
);
  import macd_pkg::*;

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [WEIGHT_W-1:0] fast_k, slow_k, sig_k;
  logic                dbl;
  logic                wbusy;

  // config registers and weight divider
  macd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fast_k    (fast_k),
    .slow_k    (slow_k),
    .sig_k     (sig_k),
    .dbl       (dbl),
    .busy      (wbusy)
  );

  // sequencer: accept, walk the six EMA updates or the series-start loads, hand off the result
  macd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_series_start (in_series_start),
    .wbusy           (wbusy),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .stat            (stat)
  );

  // averages, shared multiplier and output register
  macd_dp #(
    .PRICE_WIDTH     (PRICE_WIDTH),
    .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_price         (in_price),
    .fast_k           (fast_k),
    .slow_k           (slow_k),
    .sig_k            (sig_k),
    .dbl              (dbl),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_macd_value   (out_macd_value),
    .out_signal_value (out_signal_value),
    .out_hist_value   (out_hist_value)
  );

endmodule

`default_nettype wire

FILE: rtl/core/macd_chk.sv
`default_nettype none

module macd_chk #(
  parameter int PRICE_WIDTH = 32
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [PRICE_WIDTH:0]       out_macd_value,
  input wire logic signed [PRICE_WIDTH:0]       out_signal_value,
  input wire logic signed [PRICE_WIDTH+1:0]     out_hist_value,
  input wire logic                              cfg_we,
  input wire logic        [1:0]                 cfg_index
);
  import macd_pkg::*;

  // one item at a time: after an accept the input side must stall
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  // a period write refreshes a weight, so the next cycle must stall
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index != CFG_DOUBLE)) |=> in_stall)
    else $error("input not stalled during weight refresh");

  a_hist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hist_value ==
      ({out_macd_value[PRICE_WIDTH], out_macd_value}
       - {out_signal_value[PRICE_WIDTH], out_signal_value})))
    else $error("histogram differs from macd minus signal");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_macd_value)
      && $stable(out_signal_value) && $stable(out_hist_value)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind macd_indicator_core macd_chk #(.PRICE_WIDTH(PRICE_WIDTH)) u_macd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_macd_value   (out_macd_value),
  .out_signal_value (out_signal_value),
  .out_hist_value   (out_hist_value),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index)
);

`default_nettype wire

FILE: tb/tb_macd_indicator_core.sv
`timescale 1ns / 100ps

module tb_macd_indicator_core;
  import macd_pkg::*;

  localparam int PRICE_W     = 32;
  localparam int FRAC_EXTRA  = 16;
  // cycles with no handshake at all before the run is called hung
  localparam int STALL_LIMIT = 4000;
  // long receiver hold-off used to fill the block and back up the input
  localparam int HOLD_OFF    = 300;

  typedef logic signed [63:0] wide_t;

  // one result item: MACD line, signal line, histogram
  typedef struct packed {
    logic signed [PRICE_W:0]   macd;
    logic signed [PRICE_W:0]   signal;
    logic signed [PRICE_W+1:0] hist;
  } macd_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid;
  logic                         in_stall;
  logic [PRICE_W-1:0]           in_price;
  logic                         in_series_start;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [PRICE_W:0]      out_macd_value;
  logic signed [PRICE_W:0]      out_signal_value;
  logic signed [PRICE_W+1:0]    out_hist_value;
  logic                         cfg_we;
  cfg_idx_t                     cfg_index;
  logic [PERIOD_W-1:0]          cfg_wdata;

  // predictor copy of the registers and the six averages (EXTRA fraction bits)
  logic [PERIOD_W-1:0] fast_len, slow_len, sig_len;
  logic                dbl_mode;
  wide_t               fast_ema, fast_ema2, slow_ema, slow_ema2, sig_ema, sig_ema2;

  macd_point_t pending_results[$];

  // shared between the stimulus, the receiver and the checker
  logic        calm = 1'b0;        // no random idling on either side
  int unsigned rx_hold_req = 0;    // receiver hold-off request, in cycles
  int unsigned prices_sent = 0;
  int unsigned series_started = 0;
  int unsigned settings_used = 1;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  macd_indicator_core #(
    .PRICE_WIDTH     (PRICE_W),
    .EXTRA_FRAC_BITS (FRAC_EXTRA)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_price         (in_price),
    .in_series_start  (in_series_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_macd_value   (out_macd_value),
    .out_signal_value (out_signal_value),
    .out_hist_value   (out_hist_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q1.16 weight floor(2^17 / (n+1)); a zero period acts as period 1
  function automatic logic [WEIGHT_W-1:0] ema_weight(input logic [PERIOD_W-1:0] n);
    logic [WEIGHT_W:0] span;
    span = (n == '0) ? (WEIGHT_W+1)'(2) : (WEIGHT_W+1)'(n) + 1'b1;
    return WEIGHT_W'(((WEIGHT_W+1)'(1) << (WEIGHT_FRAC + 1)) / span);
  endfunction

  // e + floor(k * (x - e) / 2^16): the floor rounds a falling step away from e
  function automatic wide_t ema_advance(input wide_t avg, input wide_t target,
                                        input logic [WEIGHT_W-1:0] k);
    wide_t             diff;
    logic signed [81:0] prod;
    diff = target - avg;
    prod = diff * $signed({1'b0, k});
    return avg + wide_t'(prod >>> WEIGHT_FRAC);
  endfunction

  // advance the averages by one price and return the expected result item
  function automatic macd_point_t macd_predict(input logic [PRICE_W-1:0] price,
                                               input logic start);
    wide_t                px, line, sig;
    logic [WEIGHT_W-1:0]  kf, ks, kg;
    macd_point_t          pt;
    px = $signed({{(64 - PRICE_W - FRAC_EXTRA){1'b0}}, price, {FRAC_EXTRA{1'b0}}});
    kf = ema_weight(fast_len);
    ks = ema_weight(slow_len);
    kg = ema_weight(sig_len);
    if (start) begin
      fast_ema  = px;
      fast_ema2 = px;
      slow_ema  = px;
      slow_ema2 = px;
    end else begin
      fast_ema  = ema_advance(fast_ema, px, kf);
      fast_ema2 = ema_advance(fast_ema2, fast_ema, kf);
      slow_ema  = ema_advance(slow_ema, px, ks);
      slow_ema2 = ema_advance(slow_ema2, slow_ema, ks);
    end
    line = dbl_mode ? fast_ema2 - slow_ema2 : fast_ema - slow_ema;
    if (start) begin
      sig_ema  = line;
      sig_ema2 = line;
    end else begin
      sig_ema  = ema_advance(sig_ema, line, kg);
      sig_ema2 = ema_advance(sig_ema2, sig_ema, kg);
    end
    sig = dbl_mode ? sig_ema2 : sig_ema;
    // drop the extra fraction bits, rounding toward minus infinity
    pt.macd   = (PRICE_W+1)'(line >>> FRAC_EXTRA);
    pt.signal = (PRICE_W+1)'(sig >>> FRAC_EXTRA);
    pt.hist   = pt.macd - pt.signal;
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driver tasks
  // ---------------------------------------------------------------------------

  // Offer one price item; return at the edge that accepts it with valid still
  // high, so the next call can keep the channel busy without a bubble.
  task automatic send_price(input logic [PRICE_W-1:0] price, input logic start);
    // idle the sender now and then
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_price        <= price;
    in_series_start <= start;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(macd_predict(price, start));
    prices_sent++;
    if (start) series_started++;
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register while the block is idle, then hold until any weight
  // division it kicks off has finished.
  task automatic write_reg(input cfg_idx_t idx, input logic [PERIOD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FAST:   fast_len = value;
      CFG_SLOW:   slow_len = value;
      CFG_SIGNAL: sig_len  = value;
      CFG_DOUBLE: dbl_mode = value[0];
      default: ;
    endcase
    // let the division start before looking at the input stall
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return PERIOD_W'($urandom_range(1, 40));
    if (roll < 85) return PERIOD_W'($urandom);
    case ($urandom_range(2))
      0: return '0;
      1: return PERIOD_W'(1);
      default: return '1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Averages start from their zero reset values when no series start came yet.
  task automatic test_reset_state();
    send_price('1, 1'b0);
    send_price('1, 1'b0);
    send_price('0, 1'b0);
    send_price(32'h0001_0000, 1'b0);
  endtask

  // Series start loads every average, including mid-stream restarts at the
  // lowest price and at mid-scale.
  task automatic test_series_start();
    send_price('1, 1'b1);
    send_price('0, 1'b0);
    send_price('0, 1'b0);
    send_price('0, 1'b1);
    send_price('1, 1'b0);
    send_price(32'h8000_0000, 1'b1);
  endtask

  task automatic test_double_smoothing();
    drain_results();
    write_reg(CFG_DOUBLE, PERIOD_W'(1));
    settings_used++;
    send_price(32'h1234_5678, 1'b1);
    send_price('1, 1'b0);
    send_price('0, 1'b0);
    send_price(32'h0000_0001, 1'b0);
  endtask

  // Period zero acts as one; 65535 gives the smallest weight.
  task automatic test_period_extremes();
    drain_results();
    write_reg(CFG_FAST, '0);
    write_reg(CFG_SLOW, '1);
    write_reg(CFG_SIGNAL, PERIOD_W'(1));
    settings_used++;
    send_price('1, 1'b1);
    send_price('0, 1'b0);
    send_price('1, 1'b0);
    drain_results();
    write_reg(CFG_FAST, '1);
    write_reg(CFG_SLOW, '0);
    write_reg(CFG_SIGNAL, '0);
    // only bit 0 of the mode register counts
    write_reg(CFG_DOUBLE, 16'hFFFE);
    settings_used++;
    send_price('0, 1'b0);
    send_price('1, 1'b0);
    send_price('0, 1'b0);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input; then wait for every result.
  task automatic test_backpressure();
    int unsigned        i;
    logic [PRICE_W-1:0] price;
    drain_results();
    calm        = 1'b1;
    rx_hold_req = HOLD_OFF;
    price       = 32'h0064_0000;
    for (i = 0; i < 12; i++) begin
      send_price(price, i == 0);
      price = price + PRICE_W'($urandom_range(65535));
    end
    calm = 1'b0;
    drain_results();
  endtask

  // Random register settings, each followed by a run of price series. Most
  // series open with a series start and walk the price; a few are noise.
  task automatic test_random_series(input int unsigned phases,
                                    input int unsigned per_phase);
    int unsigned        p, done, len, i;
    logic [PRICE_W-1:0] price;
    logic               noisy;
    for (p = 0; p < phases; p++) begin
      drain_results();
      write_reg(CFG_FAST, pick_period());
      write_reg(CFG_SLOW, pick_period());
      write_reg(CFG_SIGNAL, pick_period());
      write_reg(CFG_DOUBLE, PERIOD_W'(p % 2));
      settings_used++;
      // one phase runs with no idling on either side
      calm = (p == 2);
      done = 0;
      while (done < per_phase) begin
        len   = $urandom_range(1, 80);
        noisy = ($urandom_range(9) == 0);
        price = $urandom();
        for (i = 0; i < len && done < per_phase; i++) begin
          if (noisy) begin
            send_price($urandom(), $urandom_range(9) == 0);
          end else begin
            if (i != 0) price = price + PRICE_W'($urandom_range(4095)) - PRICE_W'(2048);
            send_price(price, i == 0);
          end
          done++;
        end
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when one is requested
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    macd_point_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no price item outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (out_macd_value !== want.macd) begin
            $error("macd_value: expected %0d, got %0d", want.macd, out_macd_value);
            mismatches++;
          end
          if (out_signal_value !== want.signal) begin
            $error("signal_value: expected %0d, got %0d", want.signal, out_signal_value);
            mismatches++;
          end
          if (out_hist_value !== want.hist) begin
            $error("hist_value: expected %0d, got %0d", want.hist, out_hist_value);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no handshake happens for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no handshake for %0d cycles, %0d results outstanding",
           STALL_LIMIT, pending_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid        = 1'b0;
    in_price        = '0;
    in_series_start = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FAST;
    cfg_wdata       = '0;
    fast_len        = FAST_PERIOD_RST;
    slow_len        = SLOW_PERIOD_RST;
    sig_len         = SIGNAL_PERIOD_RST;
    dbl_mode        = 1'b0;
    fast_ema        = '0;
    fast_ema2       = '0;
    slow_ema        = '0;
    slow_ema2       = '0;
    sig_ema         = '0;
    sig_ema2        = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_series_start();
    test_double_smoothing();
    test_period_extremes();
    test_backpressure();
    test_random_series(7, 155);

    // drain, then give any stray result time to show up
    drain_results();
    repeat (40) @(posedge clk);

    $display("covered %0d prices in %0d series under %0d register settings; %0d results compared",
             prices_sent, series_started, settings_used, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
